[rtl/md5_message_digest_assert.svh]
// Assertion macros shared by the message digest modules.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MD5_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/md5_pkg.sv]
// Types, constants and round tables shared by the message digest modules.
package md5_pkg;

   // Kinds of input transfer.
   localparam logic REQ_ABSORB = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // Round function groups, selected by the top two bits of the round number.
   localparam logic [1:0] PH_F = 2'd0;
   localparam logic [1:0] PH_G = 2'd1;
   localparam logic [1:0] PH_H = 2'd2;
   localparam logic [1:0] PH_I = 2'd3;

   localparam int unsigned CHAIN_WORDS = 4;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned LEN_WORD_LO = 14;
   localparam int unsigned LEN_WORD_HI = 15;

   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [5:0] PAD_LIMIT      = 6'd55;
   localparam logic [5:0] ROUND_LAST     = 6'd63;
   localparam logic [7:0] PAD_MARK       = 8'h80;

   typedef logic [CHAIN_WORDS-1:0][31:0] md5_chain_type;

   localparam md5_chain_type CHAIN_INIT = {
      32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   // Additive constant of each round.
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   // Left rotate amounts, indexed by function group and the low two round bits.
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21};

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic absorb;
      logic pad;
      logic clear;
      logic len;
      logic load;
      logic step;
      logic add;
      logic restart;
   } md5_cmd_type;

   // Datapath status seen by the controller.
   typedef struct packed {
      logic pos_last;
      logic pos_long;
      logic rnd_last;
   } md5_stat_type;

   // Message word used in a given round.
   function automatic logic [3:0] msg_sel(input logic [5:0] rnd);
      logic [3:0] rl;
      logic [3:0] sel;
      rl = rnd[3:0];
      case (rnd[5:4])
         PH_F:    sel = rl;
         PH_G:    sel = rl * 4'd5 + 4'd1;
         PH_H:    sel = rl * 4'd3 + 4'd5;
         default: sel = rl * 4'd7;
      endcase
      return sel;
   endfunction

   // Rotate a word left by 0 to 31 places.
   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

[rtl/md5_ctrl.sv]
// Controller state machine: sequences absorb, padding, compression and digest output.
module md5_ctrl
   import md5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_type,
   output logic         req_tready,
   input  md5_stat_type stat,
   input  logic         out_busy,
   output md5_cmd_type  cmd,
   output logic         out_load
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_LOAD,
      ST_RUN,
      ST_ADD,
      ST_CLEAR,
      ST_EMIT
   } state_type;

   // What follows the compression that is running.
   typedef enum logic [1:0] {
      MODE_BYTE,
      MODE_SPILL,
      MODE_FINAL
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      accept;

   // Items are taken only between compressions.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_ABSORB) begin
                  cmd.absorb = 1'b1;
                  if (stat.pos_last) begin
                     mode_in  = MODE_BYTE;
                     state_in = ST_LOAD;
                  end
               end else begin
                  cmd.pad = 1'b1;
                  if (stat.pos_long) begin
                     // The length does not fit; compress the padded block first.
                     mode_in  = MODE_SPILL;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_LEN;
                  end
               end
            end
         end
         ST_LEN: begin
            cmd.len  = 1'b1;
            mode_in  = MODE_FINAL;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (stat.rnd_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            unique case (mode_ff)
               MODE_BYTE:  state_in = ST_IDLE;
               MODE_SPILL: state_in = ST_CLEAR;
               MODE_FINAL: state_in = ST_EMIT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_LEN;
         end
         ST_EMIT: begin
            // Hand the digest over once the previous one has drained.
            if (!out_busy) begin
               out_load    = 1'b1;
               cmd.restart = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and mode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_BYTE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

`include "md5_message_digest_assert.svh"

   `MD5_ASSERT_IMP(a_load_when_free, clock, reset, out_load, !out_busy, "digest loaded while output busy")
   `MD5_ASSERT_NEXT(a_run_ends_in_add, clock, reset, state_ff == ST_RUN && stat.rnd_last, state_ff == ST_ADD, "last round not followed by chain add")
   `MD5_ASSERT_IMP(a_clear_after_spill, clock, reset, state_ff == ST_CLEAR, mode_ff == MODE_SPILL, "block cleared outside a spilled finish")

endmodule

[rtl/md5_datapath.sv]
// Datapath: block buffer, bit count, chaining words and the one-round-per-cycle unit.
module md5_datapath
   import md5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  md5_cmd_type   cmd,
   input  logic [7:0]    data_byte,
   output md5_stat_type  stat,
   output md5_chain_type chain
);

   logic [BLOCK_WORDS-1:0][31:0] blk_ff, blk_in;
   md5_chain_type                chain_ff, chain_in;
   logic [63:0]                  count_ff, count_in;
   logic [31:0]                  a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]                  t_ff, t_in;
   logic [5:0]                   rnd_ff, rnd_in;
   logic [5:0]                   pos;
   logic [5:0]                   rnd_nx;
   logic [31:0]                  f;
   logic [31:0]                  sum;
   logic [31:0]                  nb;

   // Byte position in the block is bits 3 to 8 of the bit count.
   assign pos    = count_ff[8:3];
   assign rnd_nx = rnd_ff + 6'd1;

   assign stat.pos_last = (pos == BLOCK_LAST_POS);
   assign stat.pos_long = (pos > PAD_LIMIT);
   assign stat.rnd_last = (rnd_ff == ROUND_LAST);
   assign chain         = chain_ff;

   // Round function of the current group.
   always_comb begin
      case (rnd_ff[5:4])
         PH_F:    f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         PH_G:    f = c_ff ^ (d_ff & (b_ff ^ c_ff));
         PH_H:    f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   // One round: the constant plus message word comes prefetched in t_ff.
   assign sum = a_ff + f + t_ff;
   assign nb  = b_ff + rotl32(sum, ROT_AMT[{rnd_ff[5:4], rnd_ff[1:0]}]);

   // Next values of all datapath registers.
   always_comb begin
      blk_in   = blk_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      t_in     = t_ff;
      rnd_in   = rnd_ff;

      // Pack a message byte little-endian into its word.
      if (cmd.absorb) begin
         blk_in[pos[5:2]][{pos[1:0], 3'b000} +: 8] = data_byte;
         count_in = count_ff + 64'd8;
      end

      // Mark byte, then zeros up to the end of the block.
      if (cmd.pad) begin
         for (int w = 0; w < BLOCK_WORDS; w++) begin
            for (int j = 0; j < 4; j++) begin
               if (6'(w * 4 + j) == pos) begin
                  blk_in[w][j*8 +: 8] = PAD_MARK;
               end else if (6'(w * 4 + j) > pos) begin
                  blk_in[w][j*8 +: 8] = 8'h00;
               end
            end
         end
      end

      // Fresh all-zero block below the length words.
      if (cmd.clear) begin
         for (int w = 0; w < LEN_WORD_LO; w++) begin
            blk_in[w] = 32'h0;
         end
      end

      // Message length in bits, low word first.
      if (cmd.len) begin
         blk_in[LEN_WORD_LO] = count_ff[31:0];
         blk_in[LEN_WORD_HI] = count_ff[63:32];
      end

      // Start of a compression.
      if (cmd.load) begin
         a_in   = chain_ff[0];
         b_in   = chain_ff[1];
         c_in   = chain_ff[2];
         d_in   = chain_ff[3];
         rnd_in = 6'd0;
         t_in   = ROUND_K[0] + blk_ff[msg_sel(6'd0)];
      end

      // One round, and the prefetch for the next one.
      if (cmd.step) begin
         a_in   = d_ff;
         b_in   = nb;
         c_in   = b_ff;
         d_in   = c_ff;
         rnd_in = rnd_nx;
         t_in   = ROUND_K[rnd_nx] + blk_ff[msg_sel(rnd_nx)];
      end

      // Feed-forward into the chaining words.
      if (cmd.add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end

      // Back to the initial state for the next message.
      if (cmd.restart) begin
         chain_in = CHAIN_INIT;
         count_in = 64'd0;
      end
   end

   // Control and chaining state.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_INIT;
         count_ff <= 64'd0;
         rnd_ff   <= 6'd0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
      end
   end

   // Block buffer and round working registers.
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      t_ff   <= t_in;
   end

endmodule

[rtl/md5_out.sv]
// Output stage: holds one digest and hands it out as four word transfers.
module md5_out
   import md5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  md5_chain_type digest,
   output logic          busy,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   md5_chain_type words_ff, words_in;
   logic [1:0]    idx_ff, idx_in;
   logic          valid_ff, valid_in;

   assign busy       = valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = words_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 2'(CHAIN_WORDS - 1));

   // Load a digest, then step through its words one transfer at a time.
   always_comb begin
      words_in = words_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         words_in = digest;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (valid_ff && rsp_tready) begin
         idx_in = idx_ff + 2'd1;
         if (rsp_tlast) begin
            valid_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Digest words.
   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

`include "md5_message_digest_assert.svh"

   `MD5_ASSERT_NEXT(a_load_starts_at_zero, clock, reset, load, rsp_tvalid && rsp_tuser == 2'd0, "digest output does not start at word zero")

endmodule

[rtl/md5_message_digest.sv]
// Absorb: bytes are taken while idle; every 64th byte stalls the input for a compression (load, 64 rounds, add).
// The compression unit runs one round per cycle.
// Finish: the padded block with the length is compressed, after an extra block when the tail
// holds more than 55 bytes; the four words then leave on consecutive ready cycles.
// Reset: chaining words to their initial values, bit count zero, output empty;
// the block buffer is not cleared.
module md5_message_digest
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);

   md5_cmd_type   cmd;
   md5_stat_type  stat;
   md5_chain_type chain;
   logic          out_load;
   logic          out_busy;

   // Sequencer.
   md5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser[0]),
      .req_tready (req_tready),
      .stat       (stat),
      .out_busy   (out_busy),
      .cmd        (cmd),
      .out_load   (out_load)
   );

   // Block buffer, count and compression unit.
   md5_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_tdata),
      .stat      (stat),
      .chain     (chain)
   );

   // Digest output register.
   md5_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .digest     (chain),
      .busy       (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/md5_message_digest_tb.sv]
// Self-checking testbench for the streaming MD5 digest block, with a digest predictor.
`timescale 1ns / 1ps

import md5_pkg::*;

// Predicts the digest words of each message from the accepted input transfers.
class md5_digest_tracker;
   typedef struct {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain [4];
   logic [7:0]      block_bytes [64];
   logic [63:0]     bit_count;
   digest_word_type expected_words [$];
   int unsigned     failures;
   int unsigned     words_checked;

   function new();
      restart();
      foreach (block_bytes[k]) block_bytes[k] = 8'h00;
      failures = 0;
      words_checked = 0;
   endfunction

   function void restart();
      for (int k = 0; k < 4; k++) chain[k] = CHAIN_INIT[k];
      bit_count = '0;
   endfunction

   // One 64-round compression of the current block into the chaining words.
   function void compress();
      logic [31:0] a, b, c, d, f, sum, tmp, m;
      logic [5:0]  rnd;
      int unsigned g;
      int unsigned s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         rnd = r[5:0];
         case (rnd[5:4])
            PH_F: begin
               f = d ^ (b & (c ^ d));
               g = r;
            end
            PH_G: begin
               f = c ^ (d & (b ^ c));
               g = 5 * r + 1;
            end
            PH_H: begin
               f = b ^ c ^ d;
               g = 3 * r + 5;
            end
            default: begin
               f = c ^ (b | ~d);
               g = 7 * r;
            end
         endcase
         g = g % 16;
         m = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
         sum = a + f + ROUND_K[r] + m;
         s = ROT_AMT[rnd[5:4] * 4 + rnd[1:0]];
         tmp = d;
         d = c;
         c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endfunction

   // Called for every accepted input transfer.
   function void note_transfer(logic kind, logic [7:0] value);
      logic [5:0]      pos;
      digest_word_type w;
      pos = bit_count[8:3];
      if (kind == REQ_ABSORB) begin
         block_bytes[pos] = value;
         bit_count += 64'd8;
         if (pos == BLOCK_LAST_POS) compress();
      end else begin
         // Pad mark, zero fill, and an extra block when the length does not fit.
         block_bytes[pos] = PAD_MARK;
         for (int k = pos + 1; k < 64; k++) block_bytes[k] = 8'h00;
         if (pos > PAD_LIMIT) begin
            compress();
            for (int k = 0; k < 56; k++) block_bytes[k] = 8'h00;
         end
         for (int k = 0; k < 8; k++) block_bytes[56 + k] = bit_count[8*k +: 8];
         compress();
         for (int k = 0; k < 4; k++) begin
            w.word  = chain[k];
            w.index = k[1:0];
            w.last  = (k == 3);
            expected_words.push_back(w);
         end
         restart();
      end
   endfunction

   // Called for every accepted result transfer.
   function void check_word(logic [31:0] word, logic [1:0] index, logic last);
      digest_word_type w;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected digest word: expected none, actual %h", $time, word);
         failures++;
         return;
      end
      w = expected_words.pop_front();
      words_checked++;
      if (word !== w.word) begin
         $display("%0t: digest_word mismatch: expected %h, actual %h", $time, w.word, word);
         failures++;
      end
      if (index !== w.index) begin
         $display("%0t: word_index mismatch: expected %0d, actual %0d", $time, w.index, index);
         failures++;
      end
      if (last !== w.last) begin
         $display("%0t: last_word mismatch: expected %b, actual %b", $time, w.last, last);
         failures++;
      end
   endfunction

   function int unsigned pending();
      return expected_words.size();
   endfunction
endclass

module md5_message_digest_tb;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TARGET_ITEMS = 330;
   localparam int unsigned DRAIN_CYCLES = 150;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic [0:0]  req_tuser;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] digest_word
   logic [1:0]  rsp_tuser;   // [1:0] word_index
   logic        rsp_tlast;

   md5_digest_tracker tracker = new();

   int unsigned items_sent;
   int unsigned messages_sent;
   int unsigned bytes_sent;
   int unsigned idle_cycles;
   bit          sender_steady;

   md5_message_digest dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Observe both channels, feed the tracker and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_transfer(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a transfer",
                     $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // One input transfer, after a random gap unless the sender is in a steady burst.
   task automatic send_transfer(input logic kind, input logic [7:0] value);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= kind;
      req_tdata    <= value;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // A message of random bytes followed by a finish with a random, ignored data byte.
   task automatic send_message(input int unsigned length);
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < length; i++) begin
         send_transfer(REQ_ABSORB, 8'($urandom_range(0, 255)));
         bytes_sent++;
      end
      send_transfer(REQ_FINISH, 8'($urandom_range(0, 255)));
      messages_sent++;
   endtask

   // Receiver: random stalls, steady stretches, and one long hold-off to back up the block.
   initial begin
      int unsigned gap;
      int unsigned words_taken;
      bit          held;
      bit          steady;
      words_taken = 0;
      held = 1'b0;
      steady = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 5);
         if (!held && words_taken >= 8) begin
            held = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words_taken++;
         if (words_taken % 16 == 0) steady = ($urandom_range(0, 2) == 0);
      end
   end

   // Reset, directed messages, random messages, then drain.
   initial begin
      int unsigned boundary_lengths [$];
      int unsigned length;
      int unsigned reserved;
      items_sent = 0;
      messages_sent = 0;
      bytes_sent = 0;
      idle_cycles = 0;
      sender_steady = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = REQ_ABSORB;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty message, with the ignored data byte at both extremes.
      send_transfer(REQ_FINISH, 8'h00);
      send_transfer(REQ_FINISH, 8'hff);
      messages_sent += 2;
      // The classic "abc" message.
      send_transfer(REQ_ABSORB, 8'h61);
      send_transfer(REQ_ABSORB, 8'h62);
      send_transfer(REQ_ABSORB, 8'h63);
      send_transfer(REQ_FINISH, 8'h5a);
      // Byte extremes and a byte equal to the pad mark.
      send_transfer(REQ_ABSORB, 8'h00);
      send_transfer(REQ_ABSORB, 8'hff);
      send_transfer(REQ_FINISH, 8'ha5);
      send_transfer(REQ_ABSORB, PAD_MARK);
      send_transfer(REQ_FINISH, 8'h00);
      messages_sent += 3;
      bytes_sent += 6;

      // Random messages; the lengths around the padding and block boundaries
      // are mixed in at random points, and their transfers count against the budget.
      boundary_lengths = '{55, 56, 63, 64, 65};
      reserved = 0;
      foreach (boundary_lengths[k]) reserved += boundary_lengths[k] + 1;
      while (items_sent + reserved < TARGET_ITEMS || boundary_lengths.size() != 0) begin
         if (boundary_lengths.size() != 0 &&
             ($urandom_range(0, 3) == 0 || items_sent + reserved >= TARGET_ITEMS)) begin
            length = boundary_lengths.pop_front();
            reserved -= length + 1;
         end else begin
            length = $urandom_range(0, 24);
         end
         send_message(length);
      end
      req_tvalid <= 1'b0;

      // Wait for every digest word, then give the block time to emit anything stray.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d messages, %0d message bytes, %0d input transfers,",
               messages_sent, bytes_sent, items_sent);
      $display("including empty and boundary-length messages; %0d digest words checked.",
               tracker.words_checked);
      if (tracker.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
